/* rtl/assert_macros.svh */
// Assertion macros used by the top level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

/* rtl/trd_pkg.sv */
// Types and constants of the radial dead zone block.
package trd_pkg;
   localparam int unsigned SqrtCells = 16;
   localparam int unsigned DivCells  = 16;
   localparam logic [14:0] DeadZoneReset  = 15'd6000;
   localparam logic [14:0] FullScaleReset = 15'd32767;
   localparam logic [1:0]  RegDeadZone  = 2'd0;
   localparam logic [1:0]  RegFullScale = 2'd1;

   // Payload carried alongside the data through every square root cell.
   typedef struct packed {
      logic        x_neg;
      logic        y_neg;
      logic [15:0] ax;
      logic [15:0] ay;
      logic [1:0]  tag;
      logic [14:0] dz;
      logic [14:0] fs;
   } side_type;

   // State of one square root cell: remainder, partial root, radicand.
   typedef struct packed {
      logic        vld;
      side_type    sd;
      logic [32:0] rem;
      logic [16:0] root;
      logic [31:0] rad;
   } sq_type;

   // State of one divider cell: three quotients share the divisor cells.
   // The lsb_ fields hold the one numerator bit still to be shifted in.
   typedef struct packed {
      logic        vld;
      logic [1:0]  tag;
      logic        centered;
      logic        lv_sat;
      logic        x_neg;
      logic        y_neg;
      logic [16:0] mag;
      logic [14:0] den;
      logic        lsb_x;
      logic        lsb_y;
      logic        lsb_l;
      logic [32:0] rx;
      logic [32:0] ry;
      logic [32:0] rl;
      logic [16:0] qx;
      logic [16:0] qy;
      logic [16:0] ql;
   } dv_type;
endpackage

/* rtl/trd_if.sv */
// Valid and ready channels of the block.
interface trd_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] stick_x;
   logic signed [15:0] stick_y;
   logic [1:0]         pad_index;
   modport source (output valid, stick_x, stick_y, pad_index, input ready);
   modport sink   (input valid, stick_x, stick_y, pad_index, output ready);
endinterface

interface trd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic [14:0]        level;
   logic               centered;
   logic [1:0]         pad_tag;
   modport source (output valid, dir_x, dir_y, level, centered, pad_tag, input ready);
   modport sink   (input valid, dir_x, dir_y, level, centered, pad_tag, output ready);
endinterface

/* rtl/thumbstick_radial_deadzone_top.sv */
// Top level of the radial dead zone block.
// Each item passes an input stage, 16 square root cells, a set-up stage, 16 divider
// cells and an output register, one item per cycle sustained while the output is
// not stalled. The whole chain advances only when the output register is
// free or being emptied, so ready follows the result side. Registers: dead zone
// at byte 0, full scale at byte 4; they are sampled with each item on entry.
`include "assert_macros.svh"
module thumbstick_radial_deadzone_top (
   input  logic        clock,
   input  logic        reset,
   trd_req_if.sink     req,
   trd_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import trd_pkg::*;

   logic [14:0] dz_ff, fs_ff;
   logic        adv;
   sq_type      sq [0:SqrtCells];
   dv_type      dv [0:DivCells];
   dv_type      setup_in, setup_ff;
   logic        out_vld_ff;
   logic signed [15:0] ox_in, oy_in;
   logic [14:0] ol_in;
   logic signed [15:0] ox_ff, oy_ff;
   logic [14:0] ol_ff;
   logic        oc_ff;
   logic [1:0]  ot_ff;
   logic [15:0] ax, ay;
   logic [31:0] sqx, sqy;
   sq_type      in_ff, in_in;
   logic [16:0] mag;
   logic [14:0] m_clip;
   logic [14:0] lv_num;
   dv_type      last;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff <= DeadZoneReset;
         fs_ff <= FullScaleReset;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == RegFullScale[0]) begin
            fs_ff <= csr_pwdata[14:0];
         end else begin
            dz_ff <= csr_pwdata[14:0];
         end
      end
   end
   assign csr_prdata = {17'd0, (csr_paddr[2] == RegDeadZone[0]) ? dz_ff : fs_ff};

   assign adv       = !out_vld_ff || rsp.ready;
   assign req.ready = adv;

   // Squares are formed in the entry stage; the cells take the root.
   always_comb begin
      ax  = req.stick_x[15] ? 16'(-req.stick_x) : req.stick_x;
      ay  = req.stick_y[15] ? 16'(-req.stick_y) : req.stick_y;
      sqx = ax * ax;
      sqy = ay * ay;
      in_in          = '0;
      in_in.vld      = req.valid;
      in_in.sd.x_neg = req.stick_x[15];
      in_in.sd.y_neg = req.stick_y[15];
      in_in.sd.ax    = ax;
      in_in.sd.ay    = ay;
      in_in.sd.tag   = req.pad_index;
      in_in.sd.dz    = dz_ff;
      in_in.sd.fs    = fs_ff;
      in_in.rad      = sqx + sqy;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.vld <= 1'b0;
      end else if (adv) begin
         in_ff <= in_in;
      end
   end
   assign sq[0] = in_ff;

   for (genvar i = 0; i < SqrtCells; i++) begin : g_sq
      trd_sqrt_cell u_cell (.clock, .reset, .en(adv), .d_in(sq[i]), .q_out(sq[i+1]));
   end

   // The sum of two squares is at most 2^31, so its root always fits 16 bits.
   always_comb begin
      mag    = sq[SqrtCells].root;
      m_clip = (mag > {2'd0, sq[SqrtCells].sd.fs}) ? sq[SqrtCells].sd.fs : mag[14:0];
      lv_num = 15'(m_clip - sq[SqrtCells].sd.dz);
      setup_in          = '0;
      setup_in.vld      = sq[SqrtCells].vld;
      setup_in.tag      = sq[SqrtCells].sd.tag;
      setup_in.centered = mag <= {2'd0, sq[SqrtCells].sd.dz};
      setup_in.lv_sat   = sq[SqrtCells].sd.fs <= sq[SqrtCells].sd.dz;
      setup_in.x_neg    = sq[SqrtCells].sd.x_neg;
      setup_in.y_neg    = sq[SqrtCells].sd.y_neg;
      setup_in.mag      = setup_in.centered ? 17'd1 : mag;
      setup_in.den      = setup_in.lv_sat ? 15'd0
                        : 15'(sq[SqrtCells].sd.fs - sq[SqrtCells].sd.dz);
      // Numerators are n * 2^15: the remainder starts at n / 2 and the first
      // cell shifts in the low bit of n, the rest shift in zeros.
      setup_in.rx    = 33'(sq[SqrtCells].sd.ax >> 1);
      setup_in.ry    = 33'(sq[SqrtCells].sd.ay >> 1);
      setup_in.lsb_x = sq[SqrtCells].sd.ax[0];
      setup_in.lsb_y = sq[SqrtCells].sd.ay[0];
      setup_in.rl    = setup_in.lv_sat || setup_in.centered ? 33'd0 : 33'(lv_num >> 1);
      setup_in.lsb_l = setup_in.lv_sat || setup_in.centered ? 1'b0 : lv_num[0];
      setup_in.qx = '0;
      setup_in.qy = '0;
      setup_in.ql = '0;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ff.vld <= 1'b0;
      end else if (adv) begin
         setup_ff <= setup_in;
      end
   end

   assign dv[0] = setup_ff;
   for (genvar i = 0; i < DivCells; i++) begin : g_dv
      trd_div_cell u_cell (.clock, .reset, .en(adv), .d_in(dv[i]), .q_out(dv[i+1]));
   end

   always_comb begin
      last = dv[DivCells];
      if (last.x_neg) begin
         ox_in = (last.qx > 17'd32768) ? 16'sh8000 : 16'(17'd65536 - last.qx);
      end else begin
         ox_in = (last.qx > 17'd32767) ? 16'sh7fff : 16'(last.qx);
      end
      if (last.y_neg) begin
         oy_in = (last.qy > 17'd32768) ? 16'sh8000 : 16'(17'd65536 - last.qy);
      end else begin
         oy_in = (last.qy > 17'd32767) ? 16'sh7fff : 16'(last.qy);
      end
      ol_in = (last.lv_sat || last.ql > 17'd32767) ? 15'h7fff : last.ql[14:0];
      if (last.centered) begin
         ox_in = '0;
         oy_in = '0;
         ol_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= last.vld;
         ox_ff <= ox_in;
         oy_ff <= oy_in;
         ol_ff <= ol_in;
         oc_ff <= last.centered;
         ot_ff <= last.tag;
      end
   end
   assign rsp.valid    = out_vld_ff;
   assign rsp.dir_x    = ox_ff;
   assign rsp.dir_y    = oy_ff;
   assign rsp.level    = ol_ff;
   assign rsp.centered = oc_ff;
   assign rsp.pad_tag  = ot_ff;

   `ASSERT_IMPL(a_centered_zero, clock, reset, (rsp.valid && rsp.centered) |-> (rsp.level == 15'd0 && rsp.dir_x == 16'sd0), "centered item not zero")
   `ASSERT_IMPL(a_hold, clock, reset, (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.level)), "result dropped while stalled")
   `ASSERT_IMPL(a_ready, clock, reset, (!rsp.valid) |-> req.ready, "input stalled with empty output")
endmodule

/* rtl/trd_sqrt_cell.sv */
// One bit of the restoring square root: a root bit per cell.
module trd_sqrt_cell (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  trd_pkg::sq_type d_in,
   output trd_pkg::sq_type q_out
);
   import trd_pkg::*;
   sq_type      cell_ff, cell_in;
   logic [32:0] trial;
   logic [32:0] rem_sh;

   always_comb begin
      cell_in = d_in;
      rem_sh  = {d_in.rem[30:0], d_in.rad[31:30]};
      trial   = {d_in.root[14:0], 2'b01};
      cell_in.rad = {d_in.rad[29:0], 2'b00};
      if (rem_sh >= trial) begin
         cell_in.rem  = rem_sh - trial;
         cell_in.root = {d_in.root[15:0], 1'b1};
      end else begin
         cell_in.rem  = rem_sh;
         cell_in.root = {d_in.root[15:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end
   assign q_out = cell_ff;
endmodule

/* rtl/trd_div_cell.sv */
// One quotient bit for each of the three restoring divisions.
module trd_div_cell (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  trd_pkg::dv_type d_in,
   output trd_pkg::dv_type q_out
);
   import trd_pkg::*;
   dv_type      cell_ff, cell_in;
   logic [33:0] sx, sy, sl;
   logic [33:0] dm, dd;

   always_comb begin
      cell_in = d_in;
      dm = {17'd0, d_in.mag};
      dd = {19'd0, d_in.den};
      sx = {d_in.rx, d_in.lsb_x};
      sy = {d_in.ry, d_in.lsb_y};
      sl = {d_in.rl, d_in.lsb_l};
      cell_in.lsb_x = 1'b0;
      cell_in.lsb_y = 1'b0;
      cell_in.lsb_l = 1'b0;
      if (sx >= dm) begin
         cell_in.rx = 33'(sx - dm);
         cell_in.qx = {d_in.qx[15:0], 1'b1};
      end else begin
         cell_in.rx = sx[32:0];
         cell_in.qx = {d_in.qx[15:0], 1'b0};
      end
      if (sy >= dm) begin
         cell_in.ry = 33'(sy - dm);
         cell_in.qy = {d_in.qy[15:0], 1'b1};
      end else begin
         cell_in.ry = sy[32:0];
         cell_in.qy = {d_in.qy[15:0], 1'b0};
      end
      if (sl >= dd && d_in.den != 15'd0) begin
         cell_in.rl = 33'(sl - dd);
         cell_in.ql = {d_in.ql[15:0], 1'b1};
      end else begin
         cell_in.rl = sl[32:0];
         cell_in.ql = {d_in.ql[15:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end
   assign q_out = cell_ff;
endmodule

/* sim/trd_checker.sv */
// Checker that predicts and compares the results of the radial dead zone block.
`timescale 1ns / 1ps
module trd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_x,
   input  logic [15:0] req_y,
   input  logic [1:0]  req_pad,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_dir_x,
   input  logic [15:0] rsp_dir_y,
   input  logic [14:0] rsp_level,
   input  logic        rsp_centered,
   input  logic [1:0]  rsp_pad_tag,
   input  logic [14:0] dead_zone,
   input  logic [14:0] full_scale,
   output int          mismatches,
   output int          pending
);
   typedef struct packed {
      logic [15:0] dir_x;
      logic [15:0] dir_y;
      logic [14:0] level;
      logic        centered;
      logic [1:0]  pad_tag;
   } stick_result_type;

   stick_result_type expected_q[$];

   function automatic logic [16:0] radius_of(logic [15:0] x, logic [15:0] y);
      longint sx, sy, sq;
      longint r;
      sx = $signed(x);
      sy = $signed(y);
      sq = sx * sx + sy * sy;
      r = 0;
      for (int b = 16; b >= 0; b--) begin
         if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= sq) r = r + (64'd1 << b);
      end
      return r[16:0];
   endfunction

   function automatic logic [15:0] unit_q15(logic [15:0] c, logic [16:0] radius);
      longint sc, a, q;
      sc = $signed(c);
      a = sc < 0 ? -sc : sc;
      q = (a * 32768) / radius;
      if (sc < 0) begin
         if (q > 32768) q = 32768;
         return 16'(65536 - q);
      end
      if (q > 32767) q = 32767;
      return q[15:0];
   endfunction

   function automatic stick_result_type normalise(logic [15:0] x, logic [15:0] y,
                                                  logic [1:0] pad);
      stick_result_type res;
      logic [16:0] radius;
      longint m, lv;
      radius = radius_of(x, y);
      res = '0;
      res.pad_tag = pad;
      if (radius <= dead_zone) begin
         res.centered = 1'b1;
         return res;
      end
      res.dir_x = unit_q15(x, radius);
      res.dir_y = unit_q15(y, radius);
      if (full_scale <= dead_zone) begin
         res.level = 15'h7fff;
      end else begin
         m = radius > full_scale ? full_scale : radius;
         lv = ((m - dead_zone) * 32768) / (full_scale - dead_zone);
         res.level = lv > 32767 ? 15'h7fff : lv[14:0];
      end
      return res;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      stick_result_type want, got;
      if (reset) begin
         mismatches <= 0;
      end else begin
         if (req_valid && req_ready) expected_q.push_back(normalise(req_x, req_y, req_pad));
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_dir_x, rsp_dir_y, rsp_level, rsp_centered, rsp_pad_tag};
            if (expected_q.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected item: %p", got);
            end else begin
               want = expected_q.pop_front();
               if (want !== got) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10) $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
      end
   end
endmodule

/* sim/thumbstick_radial_deadzone_top_tb.sv */
// Testbench top: stimulus, register writes and verdict for the radial dead zone block.
`timescale 1ns / 1ps
module thumbstick_radial_deadzone_top_tb;
   import trd_pkg::*;

   localparam int Latency = 35;
   localparam int WatchdogLimit = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic [14:0] dead_zone = DeadZoneReset, full_scale = FullScaleReset;
   logic        calm = 1'b0;
   int          mismatches, pending, stalled;

   trd_req_if req ();
   trd_rsp_if rsp ();

   thumbstick_radial_deadzone_top dut (
      .clock, .reset, .req, .rsp,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_prdata, .csr_pready
   );

   trd_checker u_checker (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready), .req_x(req.stick_x),
      .req_y(req.stick_y), .req_pad(req.pad_index),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_dir_x(rsp.dir_x),
      .rsp_dir_y(rsp.dir_y), .rsp_level(rsp.level), .rsp_centered(rsp.centered),
      .rsp_pad_tag(rsp.pad_tag), .dead_zone, .full_scale, .mismatches, .pending
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.stick_x = '0;
      req.stick_y = '0;
      req.pad_index = '0;
      rsp.ready = 1'b0;
   end

   // The receiver stalls at random except during the calm stretch.
   always @(posedge clock) rsp.ready <= calm || ($urandom_range(99) >= 6);

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) stalled <= 0;
      else stalled <= stalled + 1;
      if (stalled >= WatchdogLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] index, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 1'b0} << 1;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index == RegDeadZone) dead_zone = value[14:0];
      else if (index == RegFullScale) full_scale = value[14:0];
   endtask

   task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [1:0] pad);
      while (!calm && $urandom_range(99) < 6) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.stick_x <= x;
      req.stick_y <= y;
      req.pad_index <= pad;
      do @(posedge clock); while (!req.ready);
   endtask

   // A clock edge passes first so that the last accepted item is already counted.
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (Latency + 5) @(posedge clock);
   endtask

   task automatic random_sample(int style);
      logic [15:0] x, y;
      int r;
      x = 16'($urandom);
      y = 16'($urandom);
      r = $urandom_range(3);
      case (style)
         0: begin
            x = 16'($signed(16'($urandom_range(2 * dead_zone + 2))) - dead_zone - 1);
            y = 16'($signed(16'($urandom_range(200))) - 100);
         end
         1: if (r == 0) x = 16'h8000; else if (r == 1) y = 16'h7fff;
         default: ;
      endcase
      send_sample(x, y, 2'($urandom_range(3)));
   endtask

   initial begin
      logic [15:0] dx [13] = '{0, 16'h7fff, 16'h8000, 0, 0, 6000, 6001, 16'h7fff,
                               16'h8000, 100, 16'hffff, 3000, 16'h8000};
      logic [15:0] dy [13] = '{0, 0, 0, 16'h7fff, 16'h8000, 0, 0, 16'h7fff,
                               16'h8000, 16'hff00, 16'hffff, 4000, 16'h7fff};
      logic [14:0] dz_set [5] = '{0, 32766, 100, 20000, 1000};
      logic [14:0] fs_set [5] = '{32767, 0, 16000, 20000, 1};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 13; i++) send_sample(dx[i], dy[i], i[1:0]);
      drain();
      write_reg(RegDeadZone, 32'hffff_0000);
      write_reg(RegFullScale, 32'h0001_7fff);
      for (int i = 0; i < 13; i++) send_sample(dx[i], dy[i], 2'(i + 1));
      drain();
      for (int phase = 0; phase < 6; phase++) begin
         if (phase > 0) begin
            write_reg(RegDeadZone, 32'(dz_set[phase - 1]));
            write_reg(RegFullScale, 32'(fs_set[phase - 1]));
         end
         calm = (phase == 2);
         for (int n = 0; n < 245; n++) begin
            random_sample($urandom_range(2));
            if (n == 120 && phase == 3) begin
               // Hold the sender back until every outstanding item has returned.
               req.valid <= 1'b0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
         end
         drain();
      end
      if (mismatches == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
